[hdl/ssbg_pkg.sv]
`default_nettype none
package ssbg_pkg;

   localparam int DEF_MAX_STOPS = 16;
   localparam int DEF_FRAC_BITS = 16;

   localparam int COORD_W = 16;
   localparam int COLOR_W = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int WGT_W   = 2 * DIFF_W;
   localparam int ACC_W   = WGT_W + DIFF_W + 2;
   localparam int NUM_W   = ACC_W + 2;
   localparam int DEN_W   = WGT_W + 1;
   localparam int RES_W   = NUM_W + 2;
   localparam int MIN_STOPS = 4;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FEW  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;
   localparam logic [1:0] STATUS_ZERO = 2'd3;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic               operation;
      logic [COORD_W-1:0] coord_u;
      logic [COORD_W-1:0] coord_v;
      logic [COLOR_W-1:0] stop_red;
      logic [COLOR_W-1:0] stop_green;
      logic [COLOR_W-1:0] stop_blue;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] out_red;
      logic [COLOR_W-1:0] out_green;
      logic [COLOR_W-1:0] out_blue;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] u;
      logic [COORD_W-1:0] v;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } stop_type;

   typedef struct packed {
      stop_type tl;
      stop_type tr;
      stop_type bl;
      stop_type br;
   } quad_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_CLASSIFY, ST_WEIGHT, ST_CHECK,
      ST_MAC, ST_DIVST, ST_DIVWAIT, ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MODE_CONC, MODE_UEDGE, MODE_VEDGE, MODE_BILIN
   } mode_type;

   // pick one color channel of a stop
   function automatic logic [COLOR_W-1:0] stop_chan(stop_type s, logic [1:0] ch);
      logic [COLOR_W-1:0] c;
      case (ch)
         CH_RED:   c = s.red;
         CH_GREEN: c = s.green;
         default:  c = s.blue;
      endcase
      return c;
   endfunction

   // signed difference of two unsigned 16-bit values
   function automatic logic signed [DIFF_W-1:0] sdiff(logic [COORD_W-1:0] a,
                                                      logic [COORD_W-1:0] b);
      return $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

endpackage
`default_nettype wire

[hdl/ssbg_cell.sv]
`default_nettype none
module ssbg_cell (
   input  wire                    clock,
   input  wire                    write_en,
   input  ssbg_pkg::stop_type     write_stop,
   input  wire                    shift_en,
   input  ssbg_pkg::stop_type     neighbor_stop,
   output ssbg_pkg::stop_type     stop
);
   import ssbg_pkg::*;

   stop_type stop_ff;
   stop_type stop_in;

   // hold, take a new stop, or pass along the ring
   always_comb begin
      stop_in = stop_ff;
      if (write_en) begin
         stop_in = write_stop;
      end else if (shift_en) begin
         stop_in = neighbor_stop;
      end
   end

   always_ff @(posedge clock) begin
      stop_ff <= stop_in;
   end

   assign stop = stop_ff;

endmodule
`default_nettype wire

[hdl/ssbg_pick.sv]
`default_nettype none
module ssbg_pick (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        clear,
   input  wire                        step,
   input  wire                        stop_valid,
   input  ssbg_pkg::stop_type         stop,
   input  wire [ssbg_pkg::COORD_W-1:0] point_u,
   input  wire [ssbg_pkg::COORD_W-1:0] point_v,
   output ssbg_pkg::quad_type         picks
);
   import ssbg_pkg::*;

   quad_type   picks_ff;
   quad_type   picks_in;
   logic [3:0] has_ff;
   logic [3:0] has_in;
   logic       le_u, ge_u, le_v, ge_v;

   assign le_u = stop.u <= point_u;
   assign ge_u = stop.u >= point_u;
   assign le_v = stop.v <= point_v;
   assign ge_v = stop.v >= point_v;

   // keep the closest qualifying stop per quadrant, later stops win ties
   always_comb begin
      picks_in = picks_ff;
      has_in   = has_ff;
      if (clear) begin
         picks_in = '0;
         has_in   = '0;
      end else if (step && stop_valid) begin
         if (le_u && le_v && (!has_ff[0] ||
             (picks_ff.tl.u <= stop.u && picks_ff.tl.v <= stop.v))) begin
            picks_in.tl = stop;
            has_in[0]   = 1'b1;
         end
         if (ge_u && le_v && (!has_ff[1] ||
             (picks_ff.tr.u >= stop.u && picks_ff.tr.v <= stop.v))) begin
            picks_in.tr = stop;
            has_in[1]   = 1'b1;
         end
         if (le_u && ge_v && (!has_ff[2] ||
             (picks_ff.bl.u <= stop.u && picks_ff.bl.v >= stop.v))) begin
            picks_in.bl = stop;
            has_in[2]   = 1'b1;
         end
         if (ge_u && ge_v && (!has_ff[3] ||
             (picks_ff.br.u >= stop.u && picks_ff.br.v >= stop.v))) begin
            picks_in.br = stop;
            has_in[3]   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_ff <= '0;
      end else begin
         has_ff <= has_in;
      end
   end

   always_ff @(posedge clock) begin
      picks_ff <= picks_in;
   end

   assign picks = picks_ff;

endmodule
`default_nettype wire

[hdl/ssbg_div.sv]
`default_nettype none
module ssbg_div #(
   parameter int NW = 55,
   parameter int DW = 35
) (
   input  wire           clock,
   input  wire           reset,
   input  wire           start,
   input  wire [NW-1:0]  dividend,
   input  wire [DW-1:0]  divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);
   import ssbg_pkg::*;

   localparam int CW = $clog2(NW + 1);

   logic [DW:0]   rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   rem_sh;
   logic [DW+1:0] trial;

   // one quotient bit per cycle while busy, restoring
   always_comb begin
      rem_sh  = {rem_ff[DW-1:0], quo_ff[NW-1]};
      trial   = {1'b0, rem_sh} - {2'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DW+1]) begin
            rem_in = trial[DW:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

[hdl/scattered_stop_bilinear_gradient_unit.sv]
// add item: the stop is stored if room; its result goes out once the output is free
// evaluate item: ring scan of the stop cells, then a bit-serial divide per channel
// one item in flight at a time; a new beat is taken while a result waits at the output
// synchronous active-high reset clears the stop count, the control state and the output
`default_nettype none
module scattered_stop_bilinear_gradient_unit #(
   parameter int MAX_STOPS = ssbg_pkg::DEF_MAX_STOPS,
   parameter int FRAC_BITS = ssbg_pkg::DEF_FRAC_BITS
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  ssbg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output ssbg_pkg::rsp_type rsp_data
);
   import ssbg_pkg::*;

   localparam int IDX_W = $clog2(MAX_STOPS);
   localparam int CNT_W = $clog2(MAX_STOPS + 1);
   localparam logic [COLOR_W-1:0] LIMIT = (FRAC_BITS >= COLOR_W) ? {COLOR_W{1'b1}} :
                                          COLOR_W'((1 << FRAC_BITS) - 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]       ch_ff, ch_in;
   logic [COORD_W-1:0] u_ff, u_in, v_ff, v_in;
   mode_type mode_ff, mode_in;
   logic signed [DIFF_W-1:0] dx1_ff, dx1_in, dx2_ff, dx2_in, dy1_ff, dy1_in, dy2_ff, dy2_in;
   logic signed [DIFF_W-1:0] sx_ff, sx_in, sy_ff, sy_in, ed_ff, ed_in, es_ff, es_in;
   logic signed [WGT_W-1:0]  w_ff [4];
   logic signed [WGT_W-1:0]  w_in [4];
   logic signed [WGT_W-1:0]  den_ff, den_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [COLOR_W-1:0] res_ff [3];
   logic [COLOR_W-1:0] res_in [3];
   logic [1:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       accept, out_free, pick_clear, scan_step, div_start, div_done;
   logic       add_we;
   stop_type   new_stop;
   stop_type   ring [MAX_STOPS];
   quad_type   picks;
   logic [NUM_W-1:0] div_quo;
   logic [NUM_W-1:0] dividend;
   logic [DEN_W-1:0] divisor;
   logic [ACC_W-1:0] acc_mag;
   logic [WGT_W-1:0] den_mag;
   logic signed [DIFF_W-1:0] coef;
   logic signed [ACC_W-1:0]  prod;
   logic signed [RES_W-1:0]  sq, sres, base;
   logic conc, uedge, vedge;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign new_stop  = '{u: req_data.coord_u, v: req_data.coord_v, red: req_data.stop_red,
                        green: req_data.stop_green, blue: req_data.stop_blue};
   assign add_we    = accept && (req_data.operation == OP_ADD) &&
                      (count_ff != CNT_W'(MAX_STOPS));

   // ring of stop cells, cell zero is the scan head
   for (genvar k = 0; k < MAX_STOPS; k++) begin : g_cell
      ssbg_cell u_cell (
         .clock         (clock),
         .write_en      (add_we && (count_ff[IDX_W-1:0] == IDX_W'(k))),
         .write_stop    (new_stop),
         .shift_en      (scan_step),
         .neighbor_stop (ring[(k + 1) % MAX_STOPS]),
         .stop          (ring[k])
      );
   end

   ssbg_pick u_pick (
      .clock      (clock),
      .reset      (reset),
      .clear      (pick_clear),
      .step       (scan_step),
      .stop_valid ({1'b0, idx_ff} < count_ff),
      .stop       (ring[0]),
      .point_u    (u_ff),
      .point_v    (v_ff),
      .picks      (picks)
   );

   ssbg_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // neighbor relations
   assign conc  = (picks.tr == picks.tl) && (picks.bl == picks.tl) && (picks.br == picks.tl);
   assign uedge = (picks.tl == picks.tr) && (picks.bl == picks.br);
   assign vedge = (picks.tl == picks.bl) && (picks.tr == picks.br);

   // coefficient of the current term and channel
   always_comb begin
      coef = '0;
      case (mode_ff)
         MODE_BILIN: begin
            case (idx_ff[1:0])
               2'd0:    coef = $signed({1'b0, stop_chan(picks.bl, ch_ff)});
               2'd1:    coef = $signed({1'b0, stop_chan(picks.br, ch_ff)});
               2'd2:    coef = $signed({1'b0, stop_chan(picks.tl, ch_ff)});
               default: coef = $signed({1'b0, stop_chan(picks.tr, ch_ff)});
            endcase
         end
         MODE_UEDGE: begin
            if (idx_ff[1:0] == 2'd0) begin
               coef = sdiff(stop_chan(picks.bl, ch_ff), stop_chan(picks.tl, ch_ff));
            end
         end
         MODE_VEDGE: begin
            if (idx_ff[1:0] == 2'd0) begin
               coef = sdiff(stop_chan(picks.tr, ch_ff), stop_chan(picks.tl, ch_ff));
            end
         end
         default: coef = '0;
      endcase
   end

   assign prod     = coef * w_ff[idx_ff[1:0]];
   assign acc_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign den_mag  = den_ff[WGT_W-1] ? WGT_W'(-den_ff) : WGT_W'(den_ff);
   assign dividend = NUM_W'({acc_mag, 1'b0}) + NUM_W'(den_mag);
   assign divisor  = {den_mag, 1'b0};
   assign sq       = (acc_ff[ACC_W-1] ^ den_ff[WGT_W-1]) ? -$signed({2'b0, div_quo})
                                                         : $signed({2'b0, div_quo});
   assign base     = (mode_ff == MODE_BILIN) ? '0
                     : $signed(RES_W'(stop_chan(picks.tl, ch_ff)));
   assign sres     = base + sq;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      ch_in        = ch_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      mode_in      = mode_ff;
      dx1_in = dx1_ff; dx2_in = dx2_ff; dy1_in = dy1_ff; dy2_in = dy2_ff;
      sx_in  = sx_ff;  sy_in  = sy_ff;  ed_in  = ed_ff;  es_in  = es_ff;
      w_in         = w_ff;
      den_in       = den_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pick_clear   = 1'b0;
      scan_step    = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               u_in      = req_data.coord_u;
               v_in      = req_data.coord_v;
               res_in    = '{default: '0};
               status_in = STATUS_OK;
               idx_in    = '0;
               state_in  = ST_FINISH;
               if (req_data.operation == OP_ADD) begin
                  if (count_ff == CNT_W'(MAX_STOPS)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end else if (count_ff < CNT_W'(MIN_STOPS)) begin
                  status_in = STATUS_FEW;
               end else begin
                  pick_clear = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            scan_step = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(MAX_STOPS - 1)) begin
               idx_in   = '0;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            mode_in = conc ? MODE_CONC : uedge ? MODE_UEDGE : vedge ? MODE_VEDGE : MODE_BILIN;
            dx2_in  = sdiff(picks.tr.u, u_ff);
            dx1_in  = sdiff(u_ff, picks.bl.u);
            dy2_in  = sdiff(picks.tr.v, v_ff);
            dy1_in  = sdiff(v_ff, picks.bl.v);
            sx_in   = sdiff(picks.tr.u, picks.bl.u);
            sy_in   = sdiff(picks.tr.v, picks.bl.v);
            ed_in   = uedge ? sdiff(v_ff, picks.tl.v) : sdiff(u_ff, picks.tl.u);
            es_in   = uedge ? sdiff(picks.bl.v, picks.tl.v) : sdiff(picks.tr.u, picks.tl.u);
            state_in = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            case (mode_ff)
               MODE_BILIN: begin
                  w_in[0] = dx2_ff * dy2_ff;
                  w_in[1] = dx1_ff * dy2_ff;
                  w_in[2] = dx2_ff * dy1_ff;
                  w_in[3] = dx1_ff * dy1_ff;
                  den_in  = sx_ff * sy_ff;
               end
               MODE_UEDGE, MODE_VEDGE: begin
                  w_in    = '{default: '0};
                  w_in[0] = WGT_W'(ed_ff);
                  den_in  = WGT_W'(es_ff);
               end
               default: begin
                  w_in   = '{default: '0};
                  den_in = WGT_W'(1);
               end
            endcase
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            acc_in = '0;
            ch_in  = CH_RED;
            idx_in = '0;
            if (den_ff == '0) begin
               status_in = STATUS_ZERO;
               state_in  = ST_FINISH;
            end else begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            acc_in = acc_ff + prod;
            idx_in = idx_ff + 1'b1;
            if (idx_ff[1:0] == 2'd3) begin
               state_in = ST_DIVST;
            end
         end
         ST_DIVST: begin
            div_start = 1'b1;
            state_in  = ST_DIVWAIT;
         end
         ST_DIVWAIT: begin
            if (div_done) begin
               if (sres[RES_W-1]) begin
                  res_in[ch_ff] = '0;
               end else if (sres > $signed(RES_W'(LIMIT))) begin
                  res_in[ch_ff] = LIMIT;
               end else begin
                  res_in[ch_ff] = sres[COLOR_W-1:0];
               end
               acc_in = '0;
               idx_in = '0;
               if (ch_ff == CH_BLUE) begin
                  state_in = ST_FINISH;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = ST_MAC;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_red: res_ff[0], out_green: res_ff[1],
                                out_blue: res_ff[2], status: status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;  ch_ff <= ch_in;  u_ff <= u_in;  v_ff <= v_in;
      mode_ff <= mode_in;
      dx1_ff <= dx1_in;  dx2_ff <= dx2_in;  dy1_ff <= dy1_in;  dy2_ff <= dy2_in;
      sx_ff <= sx_in;  sy_ff <= sy_in;  ed_ff <= ed_in;  es_ff <= es_in;
      w_ff <= w_in;  den_ff <= den_in;  acc_ff <= acc_in;
      res_ff <= res_in;  status_ff <= status_in;  rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stop count stays within the table
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(MAX_STOPS))
      else $error("stop count beyond table size");

   // count moves only on an accepted add beat
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(accept && req_data.operation == OP_ADD))
      else $error("stop count changed without an add beat");

   // a failing status carries a zero color
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != STATUS_OK) |->
      (rsp_data_ff.out_red == '0 && rsp_data_ff.out_green == '0 &&
       rsp_data_ff.out_blue == '0))
      else $error("nonzero color with failing status");

   // divider result only arrives while waiting on it
   assert property (@(posedge clock) disable iff (reset) div_done |-> state_ff == ST_DIVWAIT)
      else $error("divider done outside wait state");

   // finishing with a free output always produces a beat
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> rsp_valid_ff)
      else $error("finished item lost");

endmodule
`default_nettype wire
